// ----- src/affine_bilinear_warp_top_macros.svh -----
// Assertion macros for the affine bilinear warp block.
`ifndef AFFINE_BILINEAR_WARP_TOP_MACROS_SVH
`define AFFINE_BILINEAR_WARP_TOP_MACROS_SVH

// same-cycle implication, disabled in reset
`define ABW_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define ABW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/abw_pkg.sv -----
// Shared constants, types and arithmetic helpers for the affine bilinear warp block.
package abw_pkg;

    localparam int SRC_MAX_WIDTH  = 256;
    localparam int SRC_MAX_HEIGHT = 256;
    localparam int COEF_FRAC_BITS = 16;
    localparam int SUBPIX_BITS    = 5;
    localparam int AB_BITS        = 10;
    localparam int COEF_SHIFT     = COEF_FRAC_BITS - AB_BITS;
    localparam int POS_BIAS       = (1 << AB_BITS) / (1 << SUBPIX_BITS) / 2;

    localparam int PIX_W      = 24;
    localparam int NUM_BANKS  = 4;
    localparam int BANK_DEPTH = (SRC_MAX_WIDTH / 2) * (SRC_MAX_HEIGHT / 2);
    localparam int BANK_AW    = $clog2(BANK_DEPTH);

    localparam int TERM_W = 42;
    localparam int RND_W  = TERM_W - COEF_SHIFT;
    localparam int SUM_W  = RND_W + 1;
    localparam int POS_W  = SUM_W - (AB_BITS - SUBPIX_BITS);
    localparam int NB_W   = POS_W - SUBPIX_BITS + 1;
    localparam int WGT_W  = AB_BITS + 1;
    localparam int ACC_W  = WGT_W + 8;

    localparam int PADDR_W = 5;

    typedef logic [2:0] t_reg_idx;
    localparam t_reg_idx REG_INV_XX    = 3'd0;
    localparam t_reg_idx REG_INV_XY    = 3'd1;
    localparam t_reg_idx REG_INV_X_OFF = 3'd2;
    localparam t_reg_idx REG_INV_YX    = 3'd3;
    localparam t_reg_idx REG_INV_YY    = 3'd4;
    localparam t_reg_idx REG_INV_Y_OFF = 3'd5;
    localparam t_reg_idx REG_SRC_W     = 3'd6;
    localparam t_reg_idx REG_SRC_H     = 3'd7;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    typedef logic signed [TERM_W-1:0] t_term;
    typedef logic signed [POS_W-1:0]  t_pos;
    typedef logic [WGT_W-1:0]         t_wgt;

    // round half to even on a shift by COEF_SHIFT
    function automatic logic signed [RND_W-1:0] rne_shr(input t_term t);
        logic signed [RND_W-1:0] q;
        logic [COEF_SHIFT-1:0]   r;
        q = t[TERM_W-1:COEF_SHIFT];
        r = t[COEF_SHIFT-1:0];
        if (r > (COEF_SHIFT)'(1 << (COEF_SHIFT - 1)) ||
            (r == (COEF_SHIFT)'(1 << (COEF_SHIFT - 1)) && q[0])) begin
            q = q + (RND_W)'(1);
        end
        return q;
    endfunction

    // map row and column terms to a position on the 1/32 grid
    function automatic t_pos map_pos(input t_term tc, input t_term tr);
        logic signed [RND_W-1:0] qc;
        logic signed [RND_W-1:0] qr;
        logic signed [SUM_W-1:0] s;
        qc = rne_shr(tc);
        qr = rne_shr(tr);
        s  = {qc[RND_W-1], qc} + {qr[RND_W-1], qr} + (SUM_W)'(POS_BIAS);
        return s[SUM_W-1:AB_BITS-SUBPIX_BITS];
    endfunction

    function automatic logic [7:0] blend(input t_wgt w00, input t_wgt w10, input t_wgt w01,
                                         input t_wgt w11, input logic [7:0] p00,
                                         input logic [7:0] p10, input logic [7:0] p01,
                                         input logic [7:0] p11);
        logic [ACC_W:0] s;
        s = (ACC_W+1)'(w00 * p00) + (ACC_W+1)'(w10 * p10) + (ACC_W+1)'(w01 * p01)
          + (ACC_W+1)'(w11 * p11) + (ACC_W+1)'(1 << (AB_BITS - 1));
        return s[AB_BITS+7:AB_BITS];
    endfunction

endpackage

// ----- src/abw_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module abw_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/affine_bilinear_warp_top.sv -----
// Top level of the affine bilinear warp block: registers, sample pipeline, banked frame store.
// Load requests write one RGB pixel into the frame store; sample requests map a destination
// coordinate through the inverse affine map (Q16.16) and return a bilinear blend of the four
// neighbouring source pixels, with neighbours outside the active source area reading as zero.
// One request is taken every clock cycle unless o_stall is high; a sample result passes the
// stage registers A to D and then the output register. The frame store is split into four
// RAM banks by the parity of x and y, so each 2x2 neighbourhood is one read per bank. Loads
// and samples pass through the same pipeline and act on the store in request order. A
// two-entry output (register plus skid) lets input continue while one result waits; the input
// stalls only when both are full. Register writes must be made only while the block is idle.
`include "affine_bilinear_warp_top_macros.svh"
module affine_bilinear_warp_top
    import abw_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_operation,
    input  logic [7:0]         i_coord_x,
    input  logic [7:0]         i_coord_y,
    input  logic [7:0]         i_pixel_red,
    input  logic [7:0]         i_pixel_green,
    input  logic [7:0]         i_pixel_blue,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [7:0]         o_out_red,
    output logic [7:0]         o_out_green,
    output logic [7:0]         o_out_blue
);

    logic signed [31:0] r_inv_xx, r_inv_xy, r_inv_x_off, r_inv_yx, r_inv_yy, r_inv_y_off;
    logic [8:0]         r_src_w, r_src_h;

    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_xx    <= 32'sd65536;
            r_inv_xy    <= '0;
            r_inv_x_off <= '0;
            r_inv_yx    <= '0;
            r_inv_yy    <= 32'sd65536;
            r_inv_y_off <= '0;
            r_src_w     <= 9'(SRC_MAX_WIDTH);
            r_src_h     <= 9'(SRC_MAX_HEIGHT);
        end else if (cfg_wr) begin
            case (paddr[PADDR_W-1:2])
                REG_INV_XX:    r_inv_xx    <= pwdata;
                REG_INV_XY:    r_inv_xy    <= pwdata;
                REG_INV_X_OFF: r_inv_x_off <= pwdata;
                REG_INV_YX:    r_inv_yx    <= pwdata;
                REG_INV_YY:    r_inv_yy    <= pwdata;
                REG_INV_Y_OFF: r_inv_y_off <= pwdata;
                REG_SRC_W:     r_src_w     <= pwdata[8:0];
                REG_SRC_H:     r_src_h     <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[PADDR_W-1:2])
            REG_INV_XX:    prdata = r_inv_xx;
            REG_INV_XY:    prdata = r_inv_xy;
            REG_INV_X_OFF: prdata = r_inv_x_off;
            REG_INV_YX:    prdata = r_inv_yx;
            REG_INV_YY:    prdata = r_inv_yy;
            REG_INV_Y_OFF: prdata = r_inv_y_off;
            REG_SRC_W:     prdata = {23'd0, r_src_w};
            REG_SRC_H:     prdata = {23'd0, r_src_h};
            default:       prdata = '0;
        endcase
    end

    // pipeline control
    logic r_skid_v, r_out_v;
    logic adv, acc;
    assign adv     = !r_skid_v;
    assign acc     = i_valid && adv;
    assign o_stall = r_skid_v;

    // stage A: products
    logic        r_va, r_opa;
    logic [7:0]  r_xa, r_ya;
    logic [23:0] r_pixa;
    t_term       r_tcx, r_trx, r_tcy, r_try;
    t_term       n_tcx, n_trx, n_tcy, n_try;

    always_comb begin
        n_tcx = TERM_W'(r_inv_xx * $signed({1'b0, i_coord_x}));
        n_trx = TERM_W'(r_inv_xy * $signed({1'b0, i_coord_y})) + TERM_W'(r_inv_x_off);
        n_tcy = TERM_W'(r_inv_yx * $signed({1'b0, i_coord_x}));
        n_try = TERM_W'(r_inv_yy * $signed({1'b0, i_coord_y})) + TERM_W'(r_inv_y_off);
    end

    // stage B: position
    logic        r_vb, r_opb;
    logic [7:0]  r_xb, r_yb;
    logic [23:0] r_pixb;
    t_pos        r_px, r_py;

    // stage C: frame store access
    logic        r_vc, r_opc;
    logic [7:0]  r_xc, r_yc;
    logic [23:0] r_pixc;
    t_pos        r_pxc, r_pyc;

    // stage D: blend
    logic        r_vd, r_opd;
    logic        r_xpd, r_ypd;
    logic [3:0]  r_maskd;
    t_wgt        r_w00, r_w10, r_w01, r_w11;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vd <= 1'b0;
        end else if (adv) begin
            r_va <= acc;
            r_vb <= r_va;
            r_vc <= r_vb;
            r_vd <= r_vc;
        end
    end

    // neighbour addressing and weights
    logic [NB_W-1:0]    x0, x1, y0, y1;
    logic [8:0]         lim_w, lim_h;
    logic               in_x0, in_x1, in_y0, in_y1;
    logic [NB_W-1:0]    xe, xo, ye, yo;
    logic               in_xe, in_xo, in_ye, in_yo;
    logic [3:0]         n_mask;
    logic [SUBPIX_BITS-1:0] ax, ay;
    logic [SUBPIX_BITS:0]   nax, nay;

    function automatic logic inside_lim(input logic [NB_W-1:0] v, input logic [8:0] lim);
        return !v[NB_W-1] && (v[NB_W-2:0] < (NB_W-1)'(lim));
    endfunction

    always_comb begin
        x0    = {r_pxc[POS_W-1], r_pxc[POS_W-1:SUBPIX_BITS]};
        y0    = {r_pyc[POS_W-1], r_pyc[POS_W-1:SUBPIX_BITS]};
        x1    = x0 + NB_W'(1);
        y1    = y0 + NB_W'(1);
        lim_w = (r_src_w > 9'(SRC_MAX_WIDTH)) ? 9'(SRC_MAX_WIDTH) : r_src_w;
        lim_h = (r_src_h > 9'(SRC_MAX_HEIGHT)) ? 9'(SRC_MAX_HEIGHT) : r_src_h;
        in_x0 = inside_lim(x0, lim_w);
        in_x1 = inside_lim(x1, lim_w);
        in_y0 = inside_lim(y0, lim_h);
        in_y1 = inside_lim(y1, lim_h);
        xe    = x0[0] ? x1 : x0;
        xo    = x0[0] ? x0 : x1;
        ye    = y0[0] ? y1 : y0;
        yo    = y0[0] ? y0 : y1;
        in_xe = x0[0] ? in_x1 : in_x0;
        in_xo = x0[0] ? in_x0 : in_x1;
        in_ye = y0[0] ? in_y1 : in_y0;
        in_yo = y0[0] ? in_y0 : in_y1;
        n_mask = {in_yo && in_xo, in_yo && in_xe, in_ye && in_xo, in_ye && in_xe};
        ax    = r_pxc[SUBPIX_BITS-1:0];
        ay    = r_pyc[SUBPIX_BITS-1:0];
        nax   = (SUBPIX_BITS+1)'(1 << SUBPIX_BITS) - {1'b0, ax};
        nay   = (SUBPIX_BITS+1)'(1 << SUBPIX_BITS) - {1'b0, ay};
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_opa   <= i_operation;
            r_xa    <= i_coord_x;
            r_ya    <= i_coord_y;
            r_pixa  <= {i_pixel_red, i_pixel_green, i_pixel_blue};
            r_tcx   <= n_tcx;
            r_trx   <= n_trx;
            r_tcy   <= n_tcy;
            r_try   <= n_try;
            r_opb   <= r_opa;
            r_xb    <= r_xa;
            r_yb    <= r_ya;
            r_pixb  <= r_pixa;
            r_px    <= map_pos(r_tcx, r_trx);
            r_py    <= map_pos(r_tcy, r_try);
            r_opc   <= r_opb;
            r_xc    <= r_xb;
            r_yc    <= r_yb;
            r_pixc  <= r_pixb;
            r_pxc   <= r_px;
            r_pyc   <= r_py;
            r_opd   <= r_opc;
            r_xpd   <= x0[0];
            r_ypd   <= y0[0];
            r_maskd <= n_mask;
            r_w00   <= WGT_W'(nax * nay);
            r_w10   <= WGT_W'({1'b0, ax} * nay);
            r_w01   <= WGT_W'(nax * {1'b0, ay});
            r_w11   <= WGT_W'({1'b0, ax} * {1'b0, ay});
        end
    end

    // four frame-store banks, indexed {y parity, x parity}
    logic [NUM_BANKS-1:0] ram_we, ram_re;
    logic [BANK_AW-1:0]   ram_raddr [NUM_BANKS];
    logic [BANK_AW-1:0]   ram_waddr;
    logic [PIX_W-1:0]     ram_rdata [NUM_BANKS];

    assign ram_waddr = {r_yc[7:1], r_xc[7:1]};

    always_comb begin
        ram_raddr[0] = {ye[7:1], xe[7:1]};
        ram_raddr[1] = {ye[7:1], xo[7:1]};
        ram_raddr[2] = {yo[7:1], xe[7:1]};
        ram_raddr[3] = {yo[7:1], xo[7:1]};
        for (int b = 0; b < NUM_BANKS; b++) begin
            ram_we[b] = adv && r_vc && (r_opc == OP_LOAD) && ({r_yc[0], r_xc[0]} == 2'(b));
            ram_re[b] = adv && r_vc && (r_opc == OP_SAMPLE);
        end
    end

    for (genvar g = 0; g < NUM_BANKS; g++) begin : g_bank
        abw_ram #(
            .WIDTH (PIX_W),
            .DEPTH (BANK_DEPTH)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (ram_we[g]),
            .i_waddr (ram_waddr),
            .i_wdata (r_pixc),
            .i_re    (ram_re[g]),
            .i_raddr (ram_raddr[g]),
            .o_rdata (ram_rdata[g])
        );
    end

    // blend
    logic [PIX_W-1:0] bank_pix [NUM_BANKS];
    logic [PIX_W-1:0] p00, p10, p01, p11;
    logic [PIX_W-1:0] res;
    logic             res_v;

    always_comb begin
        for (int b = 0; b < NUM_BANKS; b++) begin
            bank_pix[b] = r_maskd[b] ? ram_rdata[b] : '0;
        end
        p00 = bank_pix[{r_ypd, r_xpd}];
        p10 = bank_pix[{r_ypd, !r_xpd}];
        p01 = bank_pix[{!r_ypd, r_xpd}];
        p11 = bank_pix[{!r_ypd, !r_xpd}];
        res[23:16] = blend(r_w00, r_w10, r_w01, r_w11,
                           p00[23:16], p10[23:16], p01[23:16], p11[23:16]);
        res[15:8]  = blend(r_w00, r_w10, r_w01, r_w11,
                           p00[15:8], p10[15:8], p01[15:8], p11[15:8]);
        res[7:0]   = blend(r_w00, r_w10, r_w01, r_w11,
                           p00[7:0], p10[7:0], p01[7:0], p11[7:0]);
        res_v = adv && r_vd && (r_opd == OP_SAMPLE);
    end

    // output register and skid
    logic [PIX_W-1:0] r_out, r_skid;
    logic             take;
    assign take = r_out_v && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            if (r_skid_v) begin
                if (take) begin
                    r_skid_v <= 1'b0;
                end
            end else if (res_v) begin
                if (r_out_v && !take) begin
                    r_skid_v <= 1'b1;
                end else begin
                    r_out_v <= 1'b1;
                end
            end else if (take) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (take) begin
                r_out <= r_skid;
            end
        end else if (res_v) begin
            if (r_out_v && !take) begin
                r_skid <= res;
            end else begin
                r_out <= res;
            end
        end
    end

    assign o_valid     = r_out_v;
    assign o_out_red   = r_out[23:16];
    assign o_out_green = r_out[15:8];
    assign o_out_blue  = r_out[7:0];

    `ABW_ASSERT_IMPL(a_skid_needs_out, r_skid_v, r_out_v, "skid full while output empty")
    `ABW_ASSERT_IMPL(a_one_bank_write, 1'b1, $onehot0(ram_we), "load wrote several banks")
    `ABW_ASSERT_IMPL(a_no_rw_clash, ram_we != 4'd0, ram_re == 4'd0, "bank read and write at once")
    `ABW_ASSERT_NEXT(a_skid_fill, res_v && r_out_v && i_stall, r_skid_v, "result lost on stall")

endmodule
